>>> sv/fscd_pkg.sv
package fscd_pkg;

  localparam int unsigned VERTICES = 65536;
  localparam int unsigned SLOTS    = 1024;

  localparam int unsigned VIdxW  = $clog2(VERTICES);
  localparam int unsigned SlotW  = $clog2(SLOTS);
  localparam int unsigned CntW   = $clog2(SLOTS + 1);
  localparam int unsigned VtxW   = 16;
  localparam int unsigned LimitW = 11;

  localparam logic [LimitW-1:0] LimitRst = LimitW'(1024);

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e            cmd;
    logic [VtxW-1:0] vertex;
  } item_t;

  typedef struct packed {
    logic             hit;
    logic [SlotW-1:0] slot;
    logic             evict_valid;
    logic [VtxW-1:0]  evicted_vertex;
    logic             moved_valid;
    logic [VtxW-1:0]  moved_vertex;
    logic             error;
  } result_t;

  typedef struct packed {
    logic             valid;
    logic [SlotW-1:0] slot;
  } vmap_ent_t;

  typedef struct packed {
    logic             rd_en;
    logic [VIdxW-1:0] rd_addr;
    logic             wr_en;
    logic [VIdxW-1:0] wr_addr;
    vmap_ent_t        wr_data;
  } vmap_req_t;

endpackage

>>> sv/fscd_vmap.sv
module fscd_vmap (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fscd_pkg::vmap_req_t req_i,
  output fscd_pkg::vmap_ent_t rdata_o,
  output logic                clearing_o
);

  fscd_pkg::vmap_ent_t            mem_q [fscd_pkg::VERTICES];
  fscd_pkg::vmap_ent_t            rdata_q;
  logic [fscd_pkg::VIdxW-1:0]     clr_addr_q, clr_addr_d;
  logic                           clr_active_q, clr_active_d;

  always_comb begin
    clr_addr_d   = clr_addr_q;
    clr_active_d = clr_active_q;
    if (clr_active_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (&clr_addr_q) begin
        clr_active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q   <= '0;
      clr_active_q <= 1'b1;
    end else begin
      clr_addr_q   <= clr_addr_d;
      clr_active_q <= clr_active_d;
    end
  end

  // sweep marks every vertex absent after reset
  always_ff @(posedge clk_i) begin
    if (clr_active_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rdata_o    = rdata_q;
  assign clearing_o = clr_active_q;

endmodule

>>> sv/fifo_slot_cache_directory.sv
// an accepted item goes from S_IDLE to S_DECIDE; a hit, an insert into a free slot, an error
//   or a remove of the last used slot ends there, an eviction goes on through S_EVICT and S_EVSET
//   and a move through S_MOVE and S_MVCLR; busy holds off the next item until S_IDLE is reached
//   again, after the read-modify-write passes through the one-read one-write vertex and slot maps
// reset: busy stays high while the vertex map is swept to absent
// the receiver cannot stall: each result is shown for exactly one cycle
module fifo_slot_cache_directory (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  fscd_pkg::item_t                 item_i,
  output logic                            result_valid_o,
  output fscd_pkg::result_t               result_o,
  input  logic                            cfg_we_i,
  input  logic [fscd_pkg::LimitW-1:0]     cfg_wdata_i
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_EVICT  = 6'b000100,
    S_EVSET  = 6'b001000,
    S_MOVE   = 6'b010000,
    S_MVCLR  = 6'b100000
  } state_e;

  state_e                         state_q, state_d;
  logic [fscd_pkg::LimitW-1:0]    limit_q;
  logic [fscd_pkg::CntW-1:0]      fill_q, fill_d;
  logic [fscd_pkg::SlotW-1:0]     head_q, head_d;
  logic [fscd_pkg::SlotW-1:0]     hd_q, hd_d;
  logic [fscd_pkg::SlotW-1:0]     sl_q, sl_d;
  logic [fscd_pkg::VtxW-1:0]      vtx_q, vtx_d;
  fscd_pkg::cmd_e                 cmd_q, cmd_d;
  fscd_pkg::result_t              res_q, res_d;
  logic                           res_valid_q, res_valid_d;

  logic [fscd_pkg::CntW-1:0]      cap;
  logic [fscd_pkg::CntW-1:0]      fill_m1;
  logic [fscd_pkg::SlotW-1:0]     last;
  logic [fscd_pkg::VIdxW-1:0]     vidx;

  fscd_pkg::vmap_req_t            vreq;
  fscd_pkg::vmap_ent_t            vent;
  logic                           clearing;

  logic [fscd_pkg::VtxW-1:0]      s2v_mem [fscd_pkg::SLOTS];
  logic [fscd_pkg::VtxW-1:0]      s2v_rdata_q;
  logic                           s2v_we, s2v_re;
  logic [fscd_pkg::SlotW-1:0]     s2v_waddr, s2v_raddr;
  logic [fscd_pkg::VtxW-1:0]      s2v_wdata;

  fscd_vmap u_vmap (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (vreq),
    .rdata_o    (vent),
    .clearing_o (clearing)
  );

  always_comb begin
    if (limit_q == '0) begin
      cap = fscd_pkg::CntW'(1);
    end else if (limit_q > fscd_pkg::LimitW'(fscd_pkg::SLOTS)) begin
      cap = fscd_pkg::CntW'(fscd_pkg::SLOTS);
    end else begin
      cap = fscd_pkg::CntW'(limit_q);
    end
  end

  assign fill_m1 = fill_q - 1'b1;
  assign last    = fill_m1[fscd_pkg::SlotW-1:0];
  assign vidx    = vtx_q[fscd_pkg::VIdxW-1:0];
  assign busy    = (state_q != S_IDLE) || clearing;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    head_d      = head_q;
    hd_d        = hd_q;
    sl_d        = sl_q;
    vtx_d       = vtx_q;
    cmd_d       = cmd_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    vreq        = '0;
    s2v_we      = 1'b0;
    s2v_waddr   = '0;
    s2v_wdata   = '0;
    s2v_re      = 1'b0;
    s2v_raddr   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start && !busy) begin
          vreq.rd_en   = 1'b1;
          vreq.rd_addr = item_i.vertex[fscd_pkg::VIdxW-1:0];
          vtx_d        = item_i.vertex;
          cmd_d        = item_i.cmd;
          state_d      = S_DECIDE;
        end
      end
      S_DECIDE: begin
        res_d = '0;
        if (cmd_q == fscd_pkg::CMD_LOOKUP) begin
          if (vent.valid) begin
            res_d.hit   = 1'b1;
            res_d.slot  = vent.slot;
            res_valid_d = 1'b1;
            state_d     = S_IDLE;
          end else if (fill_q < cap) begin
            s2v_we             = 1'b1;
            s2v_waddr          = fill_q[fscd_pkg::SlotW-1:0];
            s2v_wdata          = vtx_q;
            vreq.wr_en         = 1'b1;
            vreq.wr_addr       = vidx;
            vreq.wr_data.valid = 1'b1;
            vreq.wr_data.slot  = fill_q[fscd_pkg::SlotW-1:0];
            fill_d             = fill_q + 1'b1;
            res_d.slot         = fill_q[fscd_pkg::SlotW-1:0];
            res_valid_d        = 1'b1;
            state_d            = S_IDLE;
          end else begin
            hd_d      = (fscd_pkg::CntW'(head_q) >= cap) ? '0 : head_q;
            s2v_re    = 1'b1;
            s2v_raddr = hd_d;
            state_d   = S_EVICT;
          end
        end else begin
          if (!vent.valid || fill_q == '0) begin
            res_d.error = 1'b1;
            res_valid_d = 1'b1;
            state_d     = S_IDLE;
          end else begin
            res_d.hit  = 1'b1;
            res_d.slot = vent.slot;
            if (vent.slot != last) begin
              sl_d      = vent.slot;
              s2v_re    = 1'b1;
              s2v_raddr = last;
              state_d   = S_MOVE;
            end else begin
              vreq.wr_en   = 1'b1;
              vreq.wr_addr = vidx;
              fill_d       = fill_m1;
              res_valid_d  = 1'b1;
              state_d      = S_IDLE;
            end
          end
        end
      end
      S_EVICT: begin
        vreq.wr_en           = 1'b1;
        vreq.wr_addr         = s2v_rdata_q[fscd_pkg::VIdxW-1:0];
        s2v_we               = 1'b1;
        s2v_waddr            = hd_q;
        s2v_wdata            = vtx_q;
        res_d.slot           = hd_q;
        res_d.evict_valid    = 1'b1;
        res_d.evicted_vertex = s2v_rdata_q;
        state_d              = S_EVSET;
      end
      S_EVSET: begin
        vreq.wr_en         = 1'b1;
        vreq.wr_addr       = vidx;
        vreq.wr_data.valid = 1'b1;
        vreq.wr_data.slot  = hd_q;
        head_d             = (fscd_pkg::CntW'(hd_q) >= cap - 1'b1) ? '0 : hd_q + 1'b1;
        res_valid_d        = 1'b1;
        state_d            = S_IDLE;
      end
      S_MOVE: begin
        s2v_we             = 1'b1;
        s2v_waddr          = sl_q;
        s2v_wdata          = s2v_rdata_q;
        vreq.wr_en         = 1'b1;
        vreq.wr_addr       = s2v_rdata_q[fscd_pkg::VIdxW-1:0];
        vreq.wr_data.valid = 1'b1;
        vreq.wr_data.slot  = sl_q;
        res_d.moved_valid  = 1'b1;
        res_d.moved_vertex = s2v_rdata_q;
        state_d            = S_MVCLR;
      end
      S_MVCLR: begin
        vreq.wr_en   = 1'b1;
        vreq.wr_addr = vidx;
        fill_d       = fill_m1;
        res_valid_d  = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= fscd_pkg::LimitRst;
      fill_q      <= '0;
      head_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      head_q      <= head_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hd_q  <= hd_d;
    sl_q  <= sl_d;
    vtx_q <= vtx_d;
    cmd_q <= cmd_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (s2v_we) begin
      s2v_mem[s2v_waddr] <= s2v_wdata;
    end
    if (s2v_re) begin
      s2v_rdata_q <= s2v_mem[s2v_raddr];
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= fscd_pkg::CntW'(fscd_pkg::SLOTS))
    else $error("fill count above slot count");

  a_accept_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> state_q == S_DECIDE)
    else $error("accepted item did not reach decide");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> state_q == S_IDLE)
    else $error("result shown while item still in flight");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.error |->
      !result_o.hit && !result_o.moved_valid && !result_o.evict_valid)
    else $error("error result carries other flags");

  a_evict_move_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(result_o.evict_valid && result_o.moved_valid))
    else $error("eviction and move in one item");

endmodule
